@@ rtl/kcd_pkg.sv @@
// kcd_pkg: shared types and constants of the key click / long press detector
// used by key_click_long_press_detector and kcd_checker; no dependencies
`timescale 1ns / 1ps

package kcd_pkg;

  // payload widths
  localparam int LEVELS_W  = 5;
  localparam int KEY_IDX_W = 3;
  localparam int TICKS_W   = 13;
  localparam int EVENT_W   = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // press counter ceiling and reset threshold
  localparam logic [TICKS_W-1:0] TICK_CEILING     = 13'd5001;
  localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 13'd1000;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_LONG_TICKS = 1'b0;
  localparam logic REG_ACTIVE_LOW = 1'b1;

  // key events
  typedef enum logic [EVENT_W-1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_CLICK   = 2'd2,
    EV_LONG    = 2'd3
  } ev_t;

endpackage

@@ rtl/key_click_long_press_detector.sv @@
// key_click_long_press_detector: per-key press / click / long press classifier
// depends on kcd_pkg; checked by kcd_checker (bound in its own file)
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  in_op, in_levels, in_key_index
// out_     output     out_valid/out_stall  out_event_res, out_raw_pressed
// cfg_     input      apb write/read       long_press_ticks (0x0), active_low (0x4)
//
// one transaction per cycle while in_stall is low; a read transaction's result
// passes the input stage and then the result register, a tick gives none
// all keys update in parallel in one pass between the two registers
// synchronous active-low reset clears all key state and loads register defaults
// a stalled result holds; the input stage stalls only when it holds a read and
// the result register is full and stalled

module key_click_long_press_detector #(
  parameter int NUM_KEYS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [kcd_pkg::LEVELS_W-1:0]   in_levels,
  input  logic [kcd_pkg::KEY_IDX_W-1:0]  in_key_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kcd_pkg::EVENT_W-1:0]    out_event_res,
  output logic                           out_raw_pressed,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [kcd_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [kcd_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [kcd_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  import kcd_pkg::*;

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic [TICKS_W-1:0] long_ticks_r;
  logic               active_low_r;
  logic               cfg_wr;
  logic               cfg_reg;

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_op_r;
  logic [LEVELS_W-1:0]  s1_levels_r;
  logic [KEY_IDX_W-1:0] s1_idx_r;
  logic                 s1_go;
  logic                 in_take;

  // key state
  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic [NUM_KEYS-1:0] last_r, last_nxt;
  logic [TICKS_W-1:0]  ticks_r [NUM_KEYS];
  logic [TICKS_W-1:0]  ticks_nxt [NUM_KEYS];
  ev_t                 event_r [NUM_KEYS];
  ev_t                 event_nxt [NUM_KEYS];

  // tick and read decode
  logic [LEVELS_W+NUM_KEYS-1:0] lvl_wide;
  logic [NUM_KEYS-1:0]          pressed_vec;
  logic                         idx_ok;
  logic [KEY_W-1:0]             key_sel;
  logic                         do_tick;
  logic                         do_read;

  // result register
  logic       out_valid_r, out_valid_nxt;
  ev_t        out_event_r;
  logic       out_raw_r;

  // apb access
  assign cfg_pready = 1'b1;
  assign cfg_reg    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (cfg_reg == REG_ACTIVE_LOW) begin
      cfg_prdata = {{(CFG_DW-1){1'b0}}, active_low_r};
    end else begin
      cfg_prdata = {{(CFG_DW-TICKS_W){1'b0}}, long_ticks_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_TICKS_RESET;
      active_low_r <= 1'b1;
    end else if (cfg_wr) begin
      if (cfg_reg == REG_LONG_TICKS) begin
        long_ticks_r <= cfg_pwdata[TICKS_W-1:0];
      end else begin
        active_low_r <= cfg_pwdata[0];
      end
    end
  end

  // input stage advances unless a read waits on a full, stalled result register
  assign s1_go    = s1_valid_r && ((s1_op_r == OP_TICK) || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r     <= in_op;
      s1_levels_r <= in_levels;
      s1_idx_r    <= in_key_index;
    end
  end

  // pressed level per key; keys without a level bit see level zero
  assign lvl_wide    = {{NUM_KEYS{1'b0}}, s1_levels_r};
  assign pressed_vec = lvl_wide[NUM_KEYS-1:0] ^ {NUM_KEYS{active_low_r}};

  assign do_tick = s1_go && (s1_op_r == OP_TICK);
  assign do_read = s1_go && (s1_op_r == OP_READ);
  assign idx_ok  = int'(s1_idx_r) < NUM_KEYS;
  assign key_sel = KEY_W'(s1_idx_r);

  // key state update: all keys on a tick, one event clear on a read
  always_comb begin
    held_nxt = held_r;
    last_nxt = last_r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ticks_nxt[k] = ticks_r[k];
      event_nxt[k] = event_r[k];
    end
    if (do_tick) begin
      last_nxt = pressed_vec;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (!held_r[k]) begin
          if (pressed_vec[k]) begin
            held_nxt[k]  = 1'b1;
            event_nxt[k] = EV_PRESS;
          end else begin
            ticks_nxt[k] = '0;
          end
        end else if (pressed_vec[k]) begin
          if (ticks_r[k] < TICK_CEILING) begin
            ticks_nxt[k] = ticks_r[k] + 1'b1;
          end
        end else begin
          held_nxt[k]  = 1'b0;
          event_nxt[k] = (ticks_r[k] >= long_ticks_r) ? EV_LONG : EV_CLICK;
          ticks_nxt[k] = '0;
        end
      end
    end else if (do_read && idx_ok) begin
      if (event_r[key_sel] inside {EV_CLICK, EV_LONG}) begin
        event_nxt[key_sel] = EV_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      last_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        ticks_r[k] <= '0;
        event_r[k] <= EV_RELEASE;
      end
    end else begin
      held_r <= held_nxt;
      last_r <= last_nxt;
      for (int k = 0; k < NUM_KEYS; k++) begin
        ticks_r[k] <= ticks_nxt[k];
        event_r[k] <= event_nxt[k];
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      out_event_r <= idx_ok ? event_r[key_sel] : EV_RELEASE;
      out_raw_r   <= idx_ok ? last_r[key_sel] : 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_raw_pressed = out_raw_r;

endmodule

@@ rtl/kcd_checker.sv @@
// kcd_checker: port-level assertions for key_click_long_press_detector
// depends on kcd_pkg; attached to the top level by the bind at the end
`timescale 1ns / 1ps

module kcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [kcd_pkg::EVENT_W-1:0] out_event_res,
  input logic                        out_raw_pressed
);

  import kcd_pkg::*;

  // a stalled result transaction stays and keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res) && $stable(out_raw_pressed))
    else $error("result changed while stalled");

  // the input side only backs up behind a full, stalled result register
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a held key always reports press, and only a held key does
  a_press_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_res == EV_PRESS) == out_raw_pressed))
    else $error("press event and raw level disagree");

endmodule

bind key_click_long_press_detector kcd_checker u_kcd_checker (.*);

@@ sim/key_click_long_press_detector_tb.sv @@
// key_click_long_press_detector_tb: self-checking bench for the key click / long press detector
// drives tick and read transactions plus apb register writes; predicts each read result
// depends on kcd_pkg and key_click_long_press_detector
`timescale 1ns / 1ps

module key_click_long_press_detector_tb;
  import kcd_pkg::*;

  localparam int NUM_KEYS = 5;

  typedef struct packed {
    ev_t  ev;
    logic raw;
  } key_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_TICK;
  logic [LEVELS_W-1:0]   in_levels = '0;
  logic [KEY_IDX_W-1:0]  in_key_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [EVENT_W-1:0]    out_event_res;
  logic                  out_raw_pressed;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // key state as the detector should hold it
  logic                  key_held [NUM_KEYS];
  logic [TICKS_W-1:0]    key_ticks [NUM_KEYS];
  ev_t                   key_event [NUM_KEYS];
  logic                  key_last [NUM_KEYS];
  logic [TICKS_W-1:0]    long_ticks;
  logic                  act_low;

  key_report_t           report_q[$];
  int                    errors = 0;
  int                    burst_left = 0;
  logic                  pin_low = 1'b1;
  int                    stall_left = 0;
  int                    stall_mode = 0;

  key_click_long_press_detector #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_levels       (in_levels),
    .in_key_index    (in_key_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_raw_pressed (out_raw_pressed),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #2 clk = ~clk;

  // key state after reset
  function automatic void clear_keys();
    long_ticks = LONG_TICKS_RESET;
    act_low    = 1'b1;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_held[k]  = 1'b0;
      key_ticks[k] = '0;
      key_event[k] = EV_RELEASE;
      key_last[k]  = 1'b0;
    end
  endfunction

  // apply one accepted transaction to the key state, queue the report of a read
  function automatic void classify_keys(input logic op, input logic [LEVELS_W-1:0] lv,
                                        input logic [KEY_IDX_W-1:0] idx);
    logic        lvl;
    logic        pressed;
    key_report_t rep;
    if (op == OP_TICK) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        lvl = (k < LEVELS_W) ? lv[k] : 1'b0;
        pressed = act_low ? ~lvl : lvl;
        key_last[k] = pressed;
        if (!key_held[k]) begin
          if (pressed) begin
            key_held[k]  = 1'b1;
            key_event[k] = EV_PRESS;
          end else begin
            key_ticks[k] = '0;
          end
        end else if (pressed) begin
          if (key_ticks[k] < TICK_CEILING) key_ticks[k] = key_ticks[k] + 1'b1;
        end else begin
          key_held[k]  = 1'b0;
          key_event[k] = (key_ticks[k] >= long_ticks) ? EV_LONG : EV_CLICK;
          key_ticks[k] = '0;
        end
      end
    end else if (idx >= NUM_KEYS) begin
      rep.ev  = EV_RELEASE;
      rep.raw = 1'b0;
      report_q.push_back(rep);
    end else begin
      rep.ev  = key_event[idx];
      rep.raw = key_last[idx];
      // a finished click or long press is handed out once
      if (key_event[idx] == EV_CLICK || key_event[idx] == EV_LONG) key_event[idx] = EV_RELEASE;
      report_q.push_back(rep);
    end
  endfunction

  // follow accepted transactions and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_LONG_TICKS) long_ticks = cfg_pwdata[TICKS_W-1:0];
        else act_low = cfg_pwdata[0];
      end
      if (in_valid && !in_stall) classify_keys(in_op, in_levels, in_key_index);
    end
  end

  // compare each delivered result with the oldest report
  always @(posedge clk) begin : check_reports
    key_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("result with no read outstanding: event_res %0d raw_pressed %0d",
               out_event_res, out_raw_pressed);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (out_event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
          errors++;
        end
        if (out_raw_pressed !== want.raw) begin
          $error("raw_pressed: expected %0d, got %0d", want.raw, out_raw_pressed);
          errors++;
        end
      end
    end
  end

  // result side stalls in modes: none, light, half, heavy
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // one transaction; valid stays up inside a burst, drops for a gap after it
  task automatic send_item(input logic op, input logic [LEVELS_W-1:0] lv,
                           input logic [KEY_IDX_W-1:0] idx);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_levels    <= lv;
    in_key_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic tick_keys(input logic [LEVELS_W-1:0] pressed_mask);
    send_item(OP_TICK, pin_low ? ~pressed_mask : pressed_mask,
              KEY_IDX_W'($urandom_range(0, 7)));
  endtask

  task automatic read_key(input logic [KEY_IDX_W-1:0] idx);
    send_item(OP_READ, LEVELS_W'($urandom_range(0, 31)), idx);
  endtask

  // stop sending and let every read result and the last tick drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic regsel, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {regsel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [TICKS_W-1:0] thr, input logic low);
    settle();
    write_reg(REG_LONG_TICKS, CFG_DW'(thr));
    write_reg(REG_ACTIVE_LOW, CFG_DW'(low));
    pin_low = low;
  endtask

  // reads straight out of reset, in range and beyond the last key
  task automatic test_reset_reads();
    for (int i = 0; i < 8; i++) read_key(KEY_IDX_W'(i));
  endtask

  // press and release all keys, consume clicks, overwrite an unread click
  task automatic test_click_and_overwrite();
    tick_keys(5'h00);
    tick_keys(5'h1F);
    read_key(0);
    tick_keys(5'h1F);
    tick_keys(5'h1F);
    tick_keys(5'h00);
    read_key(1);
    read_key(1);
    tick_keys(5'h01);
    read_key(0);
    tick_keys(5'h00);
    for (int i = 0; i < NUM_KEYS; i++) read_key(KEY_IDX_W'(i));
  endtask

  // active-high pins, zero threshold, then a small threshold from both sides
  task automatic test_polarity_and_zero_threshold();
    configure(13'd0, 1'b0);
    tick_keys(5'h15);
    tick_keys(5'h00);
    for (int i = 0; i < NUM_KEYS; i++) read_key(KEY_IDX_W'(i));
    configure(13'd3, 1'b1);
    tick_keys(5'h18);
    tick_keys(5'h18);
    tick_keys(5'h18);
    tick_keys(5'h08);
    tick_keys(5'h00);
    read_key(3);
    read_key(4);
  endtask

  // threshold of ten: nine counted ticks is a click, ten is a long press
  task automatic test_threshold_boundary();
    configure(13'd10, 1'b1);
    repeat (10) tick_keys(5'h03);
    tick_keys(5'h02);
    tick_keys(5'h00);
    read_key(0);
    read_key(1);
  endtask

  // thresholds at and beyond the counter ceiling turn short presses into clicks
  task automatic test_high_threshold();
    configure(TICK_CEILING, 1'b1);
    repeat (12) tick_keys(5'h03);
    read_key(1);
    tick_keys(5'h02);
    tick_keys(5'h00);
    read_key(0);
    read_key(1);
    configure(13'h1FFF, 1'b1);
    repeat (12) tick_keys(5'h04);
    tick_keys(5'h00);
    read_key(2);
    read_key(2);
  endtask

  // key presses of random length under several settings, with noise ticks
  task automatic test_random_traffic();
    logic [LEVELS_W-1:0] mask;
    logic [TICKS_W-1:0]  thr;
    int                  pick;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 9))
        0: thr = 13'd0;
        1: thr = TICK_CEILING;
        2: thr = TICKS_W'($urandom_range(5002, 8191));
        default: thr = TICKS_W'($urandom_range(1, 12));
      endcase
      configure(thr, 1'($urandom_range(0, 1)));
      mask = '0;
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          read_key(KEY_IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                           : $urandom_range(0, 4)));
        end else if (pick < 40) begin
          send_item(OP_TICK, LEVELS_W'($urandom_range(0, 31)),
                    KEY_IDX_W'($urandom_range(0, 7)));
        end else begin
          for (int k = 0; k < LEVELS_W; k++)
            if ($urandom_range(0, 5) == 0) mask[k] = ~mask[k];
          tick_keys(mask);
        end
      end
    end
  endtask

  initial begin
    clear_keys();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_reads();
    test_click_and_overwrite();
    test_polarity_and_zero_threshold();
    test_threshold_boundary();
    test_high_threshold();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("key_click_long_press_detector: match");
    end else begin
      $display("key_click_long_press_detector: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("key_click_long_press_detector: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/kcd_pkg.sv
rtl/key_click_long_press_detector.sv
rtl/kcd_checker.sv
sim/key_click_long_press_detector_tb.sv
